// ----- hw/rtl/rcc_pkg.sv -----
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared widths, constants, register map and class codes of the RGB color
// classifier.
// ----------------------------------------------------------------------------
package rcc_pkg;

   localparam int NUM_CH     = 3;
   localparam int CH_RED     = 0;
   localparam int CH_GREEN   = 1;
   localparam int CH_BLUE    = 2;

   localparam int LEVEL_W    = 16;
   localparam int SUM_W      = 18;
   localparam int SHARE_W    = 10;
   localparam int PROD_W     = 26;
   localparam int DIV_W      = SUM_W + SHARE_W - 1;
   localparam int DIV_STAGES = SHARE_W;
   localparam int LATENCY    = DIV_STAGES + 2;

   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int INDEX_W    = 3;

   localparam logic [SHARE_W-1:0] SHARE_SCALE = 10'd1000;

   localparam logic [INDEX_W-1:0] REG_DARK_CLEAR    = 3'd0;
   localparam logic [INDEX_W-1:0] REG_DARK_SUM      = 3'd1;
   localparam logic [INDEX_W-1:0] REG_WHITE_LOW     = 3'd2;
   localparam logic [INDEX_W-1:0] REG_WHITE_HIGH    = 3'd3;
   localparam logic [INDEX_W-1:0] REG_DOMINANT_MIN  = 3'd4;
   localparam logic [INDEX_W-1:0] REG_DOMINANCE_MRG = 3'd5;

   localparam logic [LEVEL_W-1:0] DARK_CLEAR_RESET    = 16'd50;
   localparam logic [SUM_W-1:0]   DARK_SUM_RESET      = 18'd100;
   localparam logic [SHARE_W-1:0] WHITE_LOW_RESET     = 10'd280;
   localparam logic [SHARE_W-1:0] WHITE_HIGH_RESET    = 10'd400;
   localparam logic [SHARE_W-1:0] DOMINANT_MIN_RESET  = 10'd380;
   localparam logic [SHARE_W-1:0] DOMINANCE_MRG_RESET = 10'd100;

   typedef enum logic [2:0] {
      CLASS_BLACK   = 3'd0,
      CLASS_WHITE   = 3'd1,
      CLASS_RED     = 3'd2,
      CLASS_GREEN   = 3'd3,
      CLASS_BLUE    = 3'd4,
      CLASS_UNKNOWN = 3'd5
   } class_type;

endpackage

// ----- hw/rtl/rgb_color_classifier.sv -----
// ----------------------------------------------------------------------------
// rgb_color_classifier
// Classifies one RGBC sample per clock as black, white, red, green, blue or
// unknown, with thresholds held in APB registers.
// ----------------------------------------------------------------------------
// The block takes one sample in every clock cycle and busy stays low. Each
// result appears on rsp_color_class with rsp_valid high for one cycle, once
// the sample has passed all stages: one stage forms the channel products
// and the sum, ten stages of the pipelined share divider each resolve one
// quotient bit, and one stage classifies. Results come out in order and the
// receiver must take them as they come. Write the thresholds only while no
// sample is in flight.

module rgb_color_classifier (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rcc_pkg::LEVEL_W-1:0]  req_clear_level,
   input  logic [rcc_pkg::LEVEL_W-1:0]  req_red_level,
   input  logic [rcc_pkg::LEVEL_W-1:0]  req_green_level,
   input  logic [rcc_pkg::LEVEL_W-1:0]  req_blue_level,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_color_class,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rcc_pkg::ADDR_W-1:0]   paddr,
   input  logic [rcc_pkg::DATA_W-1:0]   pwdata,
   output logic [rcc_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);

   localparam int NS = rcc_pkg::DIV_STAGES;
   localparam int NC = rcc_pkg::NUM_CH;

   // Configuration registers.
   logic [rcc_pkg::LEVEL_W-1:0] dark_clear_ff;
   logic [rcc_pkg::SUM_W-1:0]   dark_sum_ff;
   logic [rcc_pkg::SHARE_W-1:0] white_low_ff;
   logic [rcc_pkg::SHARE_W-1:0] white_high_ff;
   logic [rcc_pkg::SHARE_W-1:0] dominant_min_ff;
   logic [rcc_pkg::SHARE_W-1:0] dominance_mrg_ff;

   logic                        accept;
   logic                        csr_write;
   logic [rcc_pkg::INDEX_W-1:0] csr_index;

   // Pipeline: entry 0 is the product stage, entries 1..NS the divider stages.
   logic [NS:0]                 valid_ff;
   logic [NS:0]                 valid_in;
   logic [NS:0]                 black_ff;
   logic [NS:0]                 black_in;
   logic [rcc_pkg::SUM_W-1:0]   sum_ff [NS+1];
   logic [rcc_pkg::SUM_W-1:0]   sum_in [NS+1];
   logic [rcc_pkg::PROD_W-1:0]  rem_ff [NS+1][NC];
   logic [rcc_pkg::PROD_W-1:0]  rem_in [NS+1][NC];
   logic [rcc_pkg::SHARE_W-1:0] quo_ff [NS+1][NC];
   logic [rcc_pkg::SHARE_W-1:0] quo_in [NS+1][NC];

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   rcc_pkg::class_type          class_ff;
   rcc_pkg::class_type          class_in;

   logic [rcc_pkg::LEVEL_W-1:0] level [NC];

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[rcc_pkg::ADDR_W-1:2];

   assign level[rcc_pkg::CH_RED]   = req_red_level;
   assign level[rcc_pkg::CH_GREEN] = req_green_level;
   assign level[rcc_pkg::CH_BLUE]  = req_blue_level;

   // ------------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         dark_clear_ff    <= rcc_pkg::DARK_CLEAR_RESET;
         dark_sum_ff      <= rcc_pkg::DARK_SUM_RESET;
         white_low_ff     <= rcc_pkg::WHITE_LOW_RESET;
         white_high_ff    <= rcc_pkg::WHITE_HIGH_RESET;
         dominant_min_ff  <= rcc_pkg::DOMINANT_MIN_RESET;
         dominance_mrg_ff <= rcc_pkg::DOMINANCE_MRG_RESET;
      end else if (csr_write) begin
         case (csr_index)
            rcc_pkg::REG_DARK_CLEAR: begin
               dark_clear_ff <= pwdata[rcc_pkg::LEVEL_W-1:0];
            end
            rcc_pkg::REG_DARK_SUM: begin
               dark_sum_ff <= pwdata[rcc_pkg::SUM_W-1:0];
            end
            rcc_pkg::REG_WHITE_LOW: begin
               white_low_ff <= pwdata[rcc_pkg::SHARE_W-1:0];
            end
            rcc_pkg::REG_WHITE_HIGH: begin
               white_high_ff <= pwdata[rcc_pkg::SHARE_W-1:0];
            end
            rcc_pkg::REG_DOMINANT_MIN: begin
               dominant_min_ff <= pwdata[rcc_pkg::SHARE_W-1:0];
            end
            rcc_pkg::REG_DOMINANCE_MRG: begin
               dominance_mrg_ff <= pwdata[rcc_pkg::SHARE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         rcc_pkg::REG_DARK_CLEAR:    prdata = rcc_pkg::DATA_W'(dark_clear_ff);
         rcc_pkg::REG_DARK_SUM:      prdata = rcc_pkg::DATA_W'(dark_sum_ff);
         rcc_pkg::REG_WHITE_LOW:     prdata = rcc_pkg::DATA_W'(white_low_ff);
         rcc_pkg::REG_WHITE_HIGH:    prdata = rcc_pkg::DATA_W'(white_high_ff);
         rcc_pkg::REG_DOMINANT_MIN:  prdata = rcc_pkg::DATA_W'(dominant_min_ff);
         rcc_pkg::REG_DOMINANCE_MRG: prdata = rcc_pkg::DATA_W'(dominance_mrg_ff);
         default:                    prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Product stage and divider stages
   // ------------------------------------------------------------------------
   always_comb begin
      logic [rcc_pkg::SUM_W-1:0] sum;
      logic [rcc_pkg::DIV_W-1:0] divisor;
      logic [rcc_pkg::DIV_W-1:0] partial;

      sum = rcc_pkg::SUM_W'(req_red_level) + rcc_pkg::SUM_W'(req_green_level)
          + rcc_pkg::SUM_W'(req_blue_level);
      valid_in[0] = accept;
      sum_in[0]   = sum;
      black_in[0] = (req_clear_level < dark_clear_ff) || (sum < dark_sum_ff)
                 || (sum == '0);
      for (int ch = 0; ch < NC; ch++) begin
         rem_in[0][ch] = rcc_pkg::PROD_W'(level[ch])
                       * rcc_pkg::PROD_W'(rcc_pkg::SHARE_SCALE);
         quo_in[0][ch] = '0;
      end

      // Stage j settles quotient bit NS-j. The share never reaches 1024
      // because each channel is at most the sum.
      for (int j = 1; j <= NS; j++) begin
         valid_in[j] = valid_ff[j-1];
         sum_in[j]   = sum_ff[j-1];
         black_in[j] = black_ff[j-1];
         for (int ch = 0; ch < NC; ch++) begin
            divisor = rcc_pkg::DIV_W'(sum_ff[j-1]) << (NS - j);
            partial = rcc_pkg::DIV_W'(rem_ff[j-1][ch]);
            if (partial >= divisor) begin
               rem_in[j][ch] = rcc_pkg::PROD_W'(partial - divisor);
               quo_in[j][ch] = quo_ff[j-1][ch]
                             | (rcc_pkg::SHARE_W'(1) << (NS - j));
            end else begin
               rem_in[j][ch] = rem_ff[j-1][ch];
               quo_in[j][ch] = quo_ff[j-1][ch];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      black_ff <= black_in;
      for (int j = 0; j <= NS; j++) begin
         sum_ff[j] <= sum_in[j];
         for (int ch = 0; ch < NC; ch++) begin
            rem_ff[j][ch] <= rem_in[j][ch];
            quo_ff[j][ch] <= quo_in[j][ch];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Classification stage
   // ------------------------------------------------------------------------
   function automatic logic in_white_band(
      input logic [rcc_pkg::SHARE_W-1:0] s,
      input logic [rcc_pkg::SHARE_W-1:0] lo,
      input logic [rcc_pkg::SHARE_W-1:0] hi
   );
      return (s > lo) && (s < hi);
   endfunction

   function automatic logic dominates(
      input logic [rcc_pkg::SHARE_W-1:0] s,
      input logic [rcc_pkg::SHARE_W-1:0] o1,
      input logic [rcc_pkg::SHARE_W-1:0] o2,
      input logic [rcc_pkg::SHARE_W-1:0] min_share,
      input logic [rcc_pkg::SHARE_W-1:0] margin
   );
      logic [rcc_pkg::SHARE_W:0] lead1;
      logic [rcc_pkg::SHARE_W:0] lead2;
      lead1 = {1'b0, o1} + {1'b0, margin};
      lead2 = {1'b0, o2} + {1'b0, margin};
      return (s > min_share) && ({1'b0, s} > lead1) && ({1'b0, s} > lead2);
   endfunction

   always_comb begin
      logic [rcc_pkg::SHARE_W-1:0] rs;
      logic [rcc_pkg::SHARE_W-1:0] gs;
      logic [rcc_pkg::SHARE_W-1:0] bs;

      rs = quo_ff[NS][rcc_pkg::CH_RED];
      gs = quo_ff[NS][rcc_pkg::CH_GREEN];
      bs = quo_ff[NS][rcc_pkg::CH_BLUE];
      rsp_valid_in = valid_ff[NS];
      if (black_ff[NS]) begin
         class_in = rcc_pkg::CLASS_BLACK;
      end else if (in_white_band(rs, white_low_ff, white_high_ff)
                && in_white_band(gs, white_low_ff, white_high_ff)
                && in_white_band(bs, white_low_ff, white_high_ff)) begin
         class_in = rcc_pkg::CLASS_WHITE;
      end else if (dominates(rs, gs, bs, dominant_min_ff, dominance_mrg_ff)) begin
         class_in = rcc_pkg::CLASS_RED;
      end else if (dominates(gs, rs, bs, dominant_min_ff, dominance_mrg_ff)) begin
         class_in = rcc_pkg::CLASS_GREEN;
      end else if (dominates(bs, rs, gs, dominant_min_ff, dominance_mrg_ff)) begin
         class_in = rcc_pkg::CLASS_BLUE;
      end else begin
         class_in = rcc_pkg::CLASS_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      class_ff <= class_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_class = class_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef SYNTH
   // Every sample transfer produces a result.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(rcc_pkg::LATENCY) rsp_valid)
      else $error("result missing after sample transfer");

   // No result appears without a matching sample transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, rcc_pkg::LATENCY))
      else $error("result without a sample transfer");

   // A finished share of a non-dark sample never exceeds the full scale.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NS] && !black_ff[NS]) |->
         ((quo_ff[NS][rcc_pkg::CH_RED] <= rcc_pkg::SHARE_SCALE)
       && (quo_ff[NS][rcc_pkg::CH_GREEN] <= rcc_pkg::SHARE_SCALE)
       && (quo_ff[NS][rcc_pkg::CH_BLUE] <= rcc_pkg::SHARE_SCALE)))
      else $error("channel share out of range");
`endif

endmodule

// ----- bench/tb_rgb_color_classifier.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_color_classifier
// Self-checking bench for the RGB color classifier. Samples are sent with
// random gaps and back-to-back bursts. Each sample's class is predicted from
// a local copy of the thresholds and compared with the result that comes
// out. The APB registers are read back after reset and after writes, and the
// thresholds are swept across reset, extreme and random settings.
// ----------------------------------------------------------------------------
module tb_rgb_color_classifier;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int MAX_GAP        = 16;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int EXTREME_COUNT  = 80;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_COUNT    = 200;

   // Indexes past the last register; writes to them must be ignored.
   localparam logic [rcc_pkg::INDEX_W-1:0] REG_SPARE_LOW  = 3'd6;
   localparam logic [rcc_pkg::INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic [rcc_pkg::LEVEL_W-1:0] clear;
      logic [rcc_pkg::LEVEL_W-1:0] red;
      logic [rcc_pkg::LEVEL_W-1:0] green;
      logic [rcc_pkg::LEVEL_W-1:0] blue;
   } color_sample_type;

   typedef struct packed {
      logic [rcc_pkg::LEVEL_W-1:0] dark_clear;
      logic [rcc_pkg::SUM_W-1:0]   dark_sum;
      logic [rcc_pkg::SHARE_W-1:0] white_low;
      logic [rcc_pkg::SHARE_W-1:0] white_high;
      logic [rcc_pkg::SHARE_W-1:0] dominant_min;
      logic [rcc_pkg::SHARE_W-1:0] margin;
   } class_thresholds_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [rcc_pkg::LEVEL_W-1:0]  req_clear_level;
   logic [rcc_pkg::LEVEL_W-1:0]  req_red_level;
   logic [rcc_pkg::LEVEL_W-1:0]  req_green_level;
   logic [rcc_pkg::LEVEL_W-1:0]  req_blue_level;
   logic                         rsp_valid;
   logic [2:0]                   rsp_color_class;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [rcc_pkg::ADDR_W-1:0]   paddr;
   logic [rcc_pkg::DATA_W-1:0]   pwdata;
   logic [rcc_pkg::DATA_W-1:0]   prdata;
   logic                         pready;

   class_thresholds_type         thresholds;
   rcc_pkg::class_type           expected_classes[$];
   int                           error_count = 0;
   int                           cycle_count = 0;
   int                           burst_left  = 0;

   rgb_color_classifier DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_clear_level (req_clear_level),
      .req_red_level   (req_red_level),
      .req_green_level (req_green_level),
      .req_blue_level  (req_blue_level),
      .rsp_valid       (rsp_valid),
      .rsp_color_class (rsp_color_class),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Class prediction
   // ------------------------------------------------------------------------
   function automatic class_thresholds_type reset_thresholds();
      class_thresholds_type t;
      t.dark_clear   = rcc_pkg::DARK_CLEAR_RESET;
      t.dark_sum     = rcc_pkg::DARK_SUM_RESET;
      t.white_low    = rcc_pkg::WHITE_LOW_RESET;
      t.white_high   = rcc_pkg::WHITE_HIGH_RESET;
      t.dominant_min = rcc_pkg::DOMINANT_MIN_RESET;
      t.margin       = rcc_pkg::DOMINANCE_MRG_RESET;
      return t;
   endfunction

   function automatic bit in_white_band(logic [31:0] share);
      return share > 32'(thresholds.white_low) && share < 32'(thresholds.white_high);
   endfunction

   function automatic bit leads_others(logic [31:0] share, logic [31:0] other_a,
                                       logic [31:0] other_b);
      logic [31:0] margin;
      margin = 32'(thresholds.margin);
      return share > 32'(thresholds.dominant_min) && share > other_a + margin &&
             share > other_b + margin;
   endfunction

   function automatic rcc_pkg::class_type classify_sample(color_sample_type s);
      logic [rcc_pkg::SUM_W-1:0] sum;
      logic [31:0]               red_share;
      logic [31:0]               green_share;
      logic [31:0]               blue_share;
      sum = rcc_pkg::SUM_W'(s.red) + rcc_pkg::SUM_W'(s.green)
          + rcc_pkg::SUM_W'(s.blue);
      if (s.clear < thresholds.dark_clear || sum < thresholds.dark_sum || sum == '0)
         return rcc_pkg::CLASS_BLACK;
      red_share   = 32'(s.red) * 32'(rcc_pkg::SHARE_SCALE) / 32'(sum);
      green_share = 32'(s.green) * 32'(rcc_pkg::SHARE_SCALE) / 32'(sum);
      blue_share  = 32'(s.blue) * 32'(rcc_pkg::SHARE_SCALE) / 32'(sum);
      if (in_white_band(red_share) && in_white_band(green_share) &&
          in_white_band(blue_share))
         return rcc_pkg::CLASS_WHITE;
      if (leads_others(red_share, green_share, blue_share))
         return rcc_pkg::CLASS_RED;
      if (leads_others(green_share, red_share, blue_share))
         return rcc_pkg::CLASS_GREEN;
      if (leads_others(blue_share, red_share, green_share))
         return rcc_pkg::CLASS_BLUE;
      return rcc_pkg::CLASS_UNKNOWN;
   endfunction

   function automatic logic [rcc_pkg::DATA_W-1:0] register_value(
      logic [rcc_pkg::INDEX_W-1:0] index);
      case (index)
         rcc_pkg::REG_DARK_CLEAR:    return rcc_pkg::DATA_W'(thresholds.dark_clear);
         rcc_pkg::REG_DARK_SUM:      return rcc_pkg::DATA_W'(thresholds.dark_sum);
         rcc_pkg::REG_WHITE_LOW:     return rcc_pkg::DATA_W'(thresholds.white_low);
         rcc_pkg::REG_WHITE_HIGH:    return rcc_pkg::DATA_W'(thresholds.white_high);
         rcc_pkg::REG_DOMINANT_MIN:  return rcc_pkg::DATA_W'(thresholds.dominant_min);
         rcc_pkg::REG_DOMINANCE_MRG: return rcc_pkg::DATA_W'(thresholds.margin);
         default:                    return 'x;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Result checking and run limit
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rcc_pkg::class_type predicted;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_classes.size() == 0) begin
               $error("color_class: expected no result, actual %0d", rsp_color_class);
               error_count++;
            end else begin
               predicted = expected_classes.pop_front();
               if (rsp_color_class !== predicted) begin
                  $error("color_class: expected %0d, actual %0d", predicted,
                         rsp_color_class);
                  error_count++;
               end
            end
         end
         if (start && !busy)
            expected_classes.push_back(classify_sample({req_clear_level,
                                                        req_red_level,
                                                        req_green_level,
                                                        req_blue_level}));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sample and register traffic
   // ------------------------------------------------------------------------
   // Mostly random gaps, with occasional stretches of back-to-back transfers.
   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   task automatic send_sample(input logic [rcc_pkg::LEVEL_W-1:0] clear_level,
                              input logic [rcc_pkg::LEVEL_W-1:0] red_level,
                              input logic [rcc_pkg::LEVEL_W-1:0] green_level,
                              input logic [rcc_pkg::LEVEL_W-1:0] blue_level);
      int gap;
      gap = next_gap();
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_clear_level = clear_level;
      req_red_level   = red_level;
      req_green_level = green_level;
      req_blue_level  = blue_level;
      start           = 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      start = 1'b0;
      while (expected_classes.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [rcc_pkg::INDEX_W-1:0] index,
                                 input logic [rcc_pkg::DATA_W-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         rcc_pkg::REG_DARK_CLEAR:
            thresholds.dark_clear   = value[rcc_pkg::LEVEL_W-1:0];
         rcc_pkg::REG_DARK_SUM:
            thresholds.dark_sum     = value[rcc_pkg::SUM_W-1:0];
         rcc_pkg::REG_WHITE_LOW:
            thresholds.white_low    = value[rcc_pkg::SHARE_W-1:0];
         rcc_pkg::REG_WHITE_HIGH:
            thresholds.white_high   = value[rcc_pkg::SHARE_W-1:0];
         rcc_pkg::REG_DOMINANT_MIN:
            thresholds.dominant_min = value[rcc_pkg::SHARE_W-1:0];
         rcc_pkg::REG_DOMINANCE_MRG:
            thresholds.margin       = value[rcc_pkg::SHARE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic read_register(input logic [rcc_pkg::INDEX_W-1:0] index);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = {index, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== register_value(index)) begin
         $error("prdata[%0d]: expected %0d, actual %0d", index, register_value(index),
                prdata);
         error_count++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic read_all_registers();
      for (int i = rcc_pkg::REG_DARK_CLEAR; i <= rcc_pkg::REG_DOMINANCE_MRG; i++)
         read_register(rcc_pkg::INDEX_W'(i));
   endtask

   task automatic program_thresholds(input class_thresholds_type t);
      write_register(rcc_pkg::REG_DARK_CLEAR, rcc_pkg::DATA_W'(t.dark_clear));
      write_register(rcc_pkg::REG_DARK_SUM, rcc_pkg::DATA_W'(t.dark_sum));
      write_register(rcc_pkg::REG_WHITE_LOW, rcc_pkg::DATA_W'(t.white_low));
      write_register(rcc_pkg::REG_WHITE_HIGH, rcc_pkg::DATA_W'(t.white_high));
      write_register(rcc_pkg::REG_DOMINANT_MIN, rcc_pkg::DATA_W'(t.dominant_min));
      write_register(rcc_pkg::REG_DOMINANCE_MRG, rcc_pkg::DATA_W'(t.margin));
   endtask

   // ------------------------------------------------------------------------
   // Random content
   // ------------------------------------------------------------------------
   function automatic class_thresholds_type random_thresholds();
      class_thresholds_type t;
      logic [95:0]          bits;
      if ($urandom_range(0, 3) == 0) begin
         // Any bit pattern, out-of-range values included.
         bits = {$urandom(), $urandom(), $urandom()};
         t = bits[$bits(class_thresholds_type)-1:0];
      end else begin
         t.dark_clear   = rcc_pkg::LEVEL_W'($urandom_range(0, 3000));
         t.dark_sum     = rcc_pkg::SUM_W'($urandom_range(0, 6000));
         t.white_low    = rcc_pkg::SHARE_W'($urandom_range(150, 330));
         t.white_high   = rcc_pkg::SHARE_W'($urandom_range(340, 520));
         t.dominant_min = rcc_pkg::SHARE_W'($urandom_range(250, 600));
         t.margin       = rcc_pkg::SHARE_W'($urandom_range(0, 300));
      end
      return t;
   endfunction

   // Shapes the channels so that every class, and the edges between them,
   // come up often enough.
   function automatic color_sample_type random_sample();
      color_sample_type s;
      int               level[3];
      int               top;
      int               k;
      k = $urandom_range(0, 2);
      case ($urandom_range(0, 4))
         0: begin
            s = {$urandom(), $urandom()};
            return s;
         end
         1: begin
            top = $urandom_range(500, 65535);
            level[0] = top;
            level[1] = $urandom_range(0, top * 3 / 5);
            level[2] = $urandom_range(0, top * 3 / 5);
         end
         2: begin
            top = $urandom_range(50, 43000);
            for (int i = 0; i < 3; i++)
               level[i] = top + $urandom_range(0, top / 2);
         end
         3: begin
            top = $urandom_range(200, 65535);
            level[0] = top;
            level[1] = top - $urandom_range(0, top / 4);
            level[2] = $urandom_range(0, top / 2);
         end
         default: begin
            for (int i = 0; i < 3; i++)
               level[i] = $urandom_range(0, 300);
         end
      endcase
      s.red   = rcc_pkg::LEVEL_W'(level[k]);
      s.green = rcc_pkg::LEVEL_W'(level[(k + 1) % 3]);
      s.blue  = rcc_pkg::LEVEL_W'(level[(k + 2) % 3]);
      s.clear = ($urandom_range(0, 3) == 0)
              ? rcc_pkg::LEVEL_W'($urandom_range(0, 300))
              : rcc_pkg::LEVEL_W'($urandom_range(0, 65535));
      return s;
   endfunction

   task automatic run_phase(input class_thresholds_type t, input int count);
      color_sample_type s;
      wait_for_results();
      program_thresholds(t);
      repeat (count) begin
         s = random_sample();
         send_sample(s.clear, s.red, s.green, s.blue);
      end
      wait_for_results();
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_register_access();
      read_all_registers();
      for (int i = rcc_pkg::REG_DARK_CLEAR; i <= rcc_pkg::REG_DOMINANCE_MRG; i++)
         write_register(rcc_pkg::INDEX_W'(i), $urandom());
      read_all_registers();
      write_register(REG_SPARE_LOW, $urandom());
      write_register(REG_SPARE_HIGH, $urandom());
      read_all_registers();
      program_thresholds(reset_thresholds());
      read_all_registers();
   endtask

   task automatic test_directed_samples();
      send_sample(16'd0, 16'd0, 16'd0, 16'd0);
      send_sample(16'd49, 16'd1000, 16'd1000, 16'd1000);
      send_sample(16'd50, 16'd1000, 16'd1000, 16'd1000);
      send_sample(16'd65535, 16'd33, 16'd33, 16'd33);
      send_sample(16'd65535, 16'd34, 16'd33, 16'd33);
      send_sample(16'd65535, 16'd65535, 16'd65535, 16'd65535);
      send_sample(16'd65535, 16'd65535, 16'd0, 16'd0);
      send_sample(16'd65535, 16'd0, 16'd65535, 16'd0);
      send_sample(16'd65535, 16'd0, 16'd0, 16'd65535);
      // Shares on the band and margin edges: equality never qualifies.
      send_sample(16'd1000, 16'd400, 16'd300, 16'd300);
      send_sample(16'd1000, 16'd401, 16'd300, 16'd299);
      send_sample(16'd1000, 16'd300, 16'd401, 16'd299);
      send_sample(16'd1000, 16'd299, 16'd300, 16'd401);
      send_sample(16'd1000, 16'd281, 16'd359, 16'd360);
      send_sample(16'd1000, 16'd280, 16'd360, 16'd360);
      send_sample(16'd1000, 16'd381, 16'd281, 16'd338);
      send_sample(16'd1000, 16'd500, 16'd500, 16'd0);
      send_sample(16'd1000, 16'd0, 16'd500, 16'd500);
      send_sample(16'd1, 16'd65535, 16'd0, 16'd0);
      wait_for_results();
   endtask

   // With both dark limits at zero an all-zero color sum still has to come
   // out black rather than divide by zero.
   task automatic test_zero_sum();
      class_thresholds_type t;
      t = reset_thresholds();
      t.dark_clear = '0;
      t.dark_sum   = '0;
      program_thresholds(t);
      send_sample(16'd0, 16'd0, 16'd0, 16'd0);
      send_sample(16'd65535, 16'd0, 16'd0, 16'd0);
      send_sample(16'd0, 16'd1, 16'd0, 16'd0);
      send_sample(16'd0, 16'd0, 16'd0, 16'd1);
      wait_for_results();
   endtask

   task automatic test_threshold_extremes();
      class_thresholds_type t;
      t = '0;
      run_phase(t, EXTREME_COUNT);
      t = '1;
      run_phase(t, EXTREME_COUNT);
      t.dark_clear = '0;
      t.dark_sum   = '0;
      run_phase(t, EXTREME_COUNT);
   endtask

   task automatic test_random_samples();
      run_phase(reset_thresholds(), PHASE_COUNT);
      for (int i = 1; i < RANDOM_PHASES; i++)
         run_phase(random_thresholds(), PHASE_COUNT);
      read_all_registers();
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_clear_level = '0;
      req_red_level   = '0;
      req_green_level = '0;
      req_blue_level  = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      thresholds      = reset_thresholds();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_access();
      test_directed_samples();
      test_zero_sum();
      test_threshold_extremes();
      test_random_samples();

      wait_for_results();
      repeat (2 * rcc_pkg::LATENCY) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
